// ----- hw/rtl/rsdc_pkg.sv -----
// Shared types and constants for the relay schedule controller.
`timescale 1ns / 1ps
`default_nettype none

package rsdc_pkg;

  localparam int unsigned CHANNELS_DEF  = 2;
  localparam int unsigned TIME_BITS_DEF = 48;

  localparam int unsigned SCHED_W = 48;
  localparam int unsigned DUR_W   = 32;
  localparam int unsigned HASH_W  = 32;

  // FNV-1a over one flag byte, 8 schedule bytes and 4 duration bytes
  localparam int unsigned HASH_BYTES = 13;
  localparam int unsigned HCNT_W     = 4;
  localparam int unsigned HSHIFT_W   = HASH_BYTES * 8;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
  localparam logic [7:0]        BYTE_MASK = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_APPLY,
    ST_TICK_INC,
    ST_TICK_SCAN,
    ST_DONE
  } rsdc_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/relay_schedule_dedup_controller.sv -----
// Relay schedule controller: server clock, hashed command dedup, per-channel off deadlines.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_*): one request is either a millisecond tick (in_command = 0) or a
//   control command for one relay channel (in_command = 1), accepted when in_valid is high
//   and in_stall is low. Each request yields exactly one result on the out_* channel,
//   accepted when out_valid is high and out_stall is low.
//   Sequencing: a request is worked on alone. A control command that acts on a channel
//   runs the byte-serial FNV-1a hash (one shared 32x32 constant multiplier), then an
//   apply step and a result step; the next request is taken after the result step.
//   A tick runs one saturating increment on the shared adder and then scans the channels
//   one per cycle on the shared comparator before its result step. A request dropped
//   before sync, and any tick before sync, goes straight to the result step.
//   The result register parts the two sides: a finished result may wait for the receiver
//   while the next request is taken and worked on; the block holds in its last step only
//   when a second result is ready before the first one has left.
//   Reset (rst_n low, synchronous): clock zero and unsynced, all relays off, deadlines and
//   last hashes zero, active_level 1, result channel empty.
//   cfg_wr_en / cfg_wr_data write active_level; write only while the block is idle.
module relay_schedule_dedup_controller
  import rsdc_pkg::*;
#(
  parameter int unsigned CHANNELS  = CHANNELS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_command,
  input  wire logic               in_channel,
  input  wire logic               in_want_on,
  input  wire logic [SCHED_W-1:0] in_start_at_ms,
  input  wire logic [DUR_W-1:0]   in_hold_ms,
  input  wire logic               in_has_now,
  input  wire logic [SCHED_W-1:0] in_sync_time_ms,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_relay_states,
  output logic [1:0]              out_drive_levels,
  output logic                    out_accepted,
  output logic                    out_time_synced
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  // result bits exist only for channels that are built
  localparam logic [1:0] PRESENT = (CHANNELS >= 2) ? 2'b11 : 2'b01;

  // ---------------------------------------------------------------- state
  rsdc_state_t state_r, state_nxt;

  logic                 active_level_r;
  logic [TIME_BITS-1:0] clock_r, clock_nxt;
  logic                 synced_r, synced_nxt;
  logic [CHANNELS-1:0]  relay_on_r, relay_on_nxt;
  logic [TIME_BITS-1:0] deadline_r [CHANNELS];
  logic [HASH_W-1:0]    last_hash_r [CHANNELS];

  // latched request
  logic [CH_W-1:0]      ch_r;
  logic                 act_r;
  logic [SCHED_W-1:0]   sched_r;
  logic [DUR_W-1:0]     dur_r;
  logic                 acc_r, acc_nxt;

  // hash engine
  logic [HSHIFT_W-1:0]  hshift_r, hshift_nxt;
  logic [HASH_W-1:0]    hash_r, hash_nxt;
  logic [HCNT_W-1:0]    hcnt_r, hcnt_nxt;
  logic [CH_W-1:0]      scan_r, scan_nxt;

  // result register
  logic                 out_valid_r;
  logic [1:0]           out_states_r;
  logic [1:0]           out_levels_r;
  logic                 out_acc_r;
  logic                 out_sync_r;

  // ------------------------------------------------------ control outputs
  logic in_take;
  logic out_free;
  logic out_load;
  logic cmd_go;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  // a command acts once the clock is synced, by itself or by the sync it carries, and its channel is built
  assign cmd_go   = (in_has_now || synced_r) && (32'(in_channel) < CHANNELS);

  // ------------------------------------------------------ shared datapath
  // One read port on the per-channel stores: the addressed channel while applying,
  // the scan index while checking deadlines on a tick.
  logic [CH_W-1:0]      rd_idx;
  logic [TIME_BITS-1:0] dl_rd;
  logic [HASH_W-1:0]    hash_rd;
  logic                 on_rd;

  assign rd_idx  = (state_r == ST_APPLY) ? ch_r : scan_r;
  assign dl_rd   = deadline_r[rd_idx];
  assign hash_rd = last_hash_r[rd_idx];
  assign on_rd   = relay_on_r[rd_idx];

  // Shared saturating adder: clock + 1 on a tick, clock + duration on a command.
  logic [TIME_BITS-1:0] add_b;
  logic [TIME_BITS:0]   add_sum;
  logic [TIME_BITS-1:0] add_sat;

  assign add_b   = (state_r == ST_TICK_INC) ? TIME_BITS'(1) : TIME_BITS'(dur_r);
  assign add_sum = {1'b0, clock_r} + {1'b0, add_b};
  assign add_sat = add_sum[TIME_BITS] ? TIME_MAX : add_sum[TIME_BITS-1:0];

  // Shared comparator: clock against the start time or against a deadline.
  logic [63:0] cmp_b;
  logic        clk_ge;

  assign cmp_b  = (state_r == ST_APPLY) ? 64'(sched_r) : 64'(dl_rd);
  assign clk_ge = 64'(clock_r) >= cmp_b;

  // Hash step: fold the top byte of the shift register (product kept mod 2^32).
  logic [7:0]        hbyte;
  logic [HASH_W-1:0] hprod;

  assign hbyte = hshift_r[HSHIFT_W-1 -: 8] & BYTE_MASK;
  assign hprod = (hash_r ^ HASH_W'(hbyte)) * FNV_PRIME;

  // ------------------------------------------------------ next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (!in_command) begin
            state_nxt = synced_r ? ST_TICK_INC : ST_DONE;
          end else begin
            state_nxt = cmd_go ? ST_HASH : ST_DONE;
          end
        end
      end
      ST_HASH: begin
        if (hcnt_r == HCNT_W'(HASH_BYTES - 1)) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY:     state_nxt = ST_DONE;
      ST_TICK_INC:  state_nxt = ST_TICK_SCAN;
      ST_TICK_SCAN: begin
        if (scan_r == LAST_CH) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------ sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_DONE: out_load = out_free;
      default: begin
        in_stall = 1'b1;
        out_load = 1'b0;
      end
    endcase
  end

  // ------------------------------------------------------ datapath next values
  logic                 wr_en;
  logic [TIME_BITS-1:0] wr_dl;
  logic                 wr_hash_en;

  always_comb begin
    clock_nxt    = clock_r;
    synced_nxt   = synced_r;
    relay_on_nxt = relay_on_r;
    acc_nxt      = acc_r;
    hshift_nxt   = hshift_r;
    hash_nxt     = hash_r;
    hcnt_nxt     = hcnt_r;
    scan_nxt     = scan_r;
    wr_en        = 1'b0;
    wr_dl        = dl_rd;
    wr_hash_en   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          acc_nxt    = 1'b0;
          hash_nxt   = FNV_BASIS;
          hcnt_nxt   = '0;
          scan_nxt   = '0;
          hshift_nxt = {7'd0, in_want_on, 16'd0, in_start_at_ms, in_hold_ms};
          if (in_command && in_has_now) begin
            clock_nxt  = TIME_BITS'(64'(in_sync_time_ms));
            synced_nxt = 1'b1;
          end
        end
      end
      ST_HASH: begin
        hash_nxt   = hprod;
        hshift_nxt = hshift_r << 8;
        hcnt_nxt   = hcnt_r + HCNT_W'(1);
      end
      ST_APPLY: begin
        acc_nxt    = 1'b1;
        wr_en      = 1'b1;
        wr_hash_en = 1'b1;
        if (!act_r) begin
          relay_on_nxt[ch_r] = 1'b0;
          wr_dl              = '0;
        end else if (sched_r == '0 || clk_ge) begin
          relay_on_nxt[ch_r] = 1'b1;
          // repeat of the last command: keep the armed deadline
          if (hash_r != hash_rd) begin
            wr_dl = (dur_r != '0) ? add_sat : '0;
          end
        end else begin
          relay_on_nxt[ch_r] = 1'b0;
          wr_dl              = '0;
        end
      end
      ST_TICK_INC: begin
        clock_nxt = add_sat;
      end
      ST_TICK_SCAN: begin
        scan_nxt = scan_r + CH_W'(1);
        if (clock_r != '0 && on_rd && dl_rd != '0 && clk_ge) begin
          relay_on_nxt[scan_r] = 1'b0;
          wr_en                = 1'b1;
          wr_dl                = '0;
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  // ------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      active_level_r <= 1'b1;
      clock_r        <= '0;
      synced_r       <= 1'b0;
      relay_on_r     <= '0;
      acc_r          <= 1'b0;
      scan_r         <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        deadline_r[i]  <= '0;
        last_hash_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      clock_r    <= clock_nxt;
      synced_r   <= synced_nxt;
      relay_on_r <= relay_on_nxt;
      acc_r      <= acc_nxt;
      scan_r     <= scan_nxt;
      if (cfg_wr_en) begin
        active_level_r <= cfg_wr_data;
      end
      if (wr_en) begin
        deadline_r[rd_idx] <= wr_dl;
      end
      if (wr_hash_en) begin
        last_hash_r[rd_idx] <= hash_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hshift_r <= hshift_nxt;
    hash_r   <= hash_nxt;
    hcnt_r   <= hcnt_nxt;
    if (in_take) begin
      ch_r    <= CH_W'(in_channel);
      act_r   <= in_want_on;
      sched_r <= in_start_at_ms;
      dur_r   <= in_hold_ms;
    end
    if (out_load) begin
      out_states_r <= 2'(relay_on_r) & PRESENT;
      out_levels_r <= (active_level_r ? 2'(relay_on_r) : ~2'(relay_on_r)) & PRESENT;
      out_acc_r    <= acc_r;
      out_sync_r   <= synced_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_relay_states = out_states_r;
  assign out_drive_levels = out_levels_r;
  assign out_accepted     = out_acc_r;
  assign out_time_synced  = out_sync_r;

  // ------------------------------------------------------ assertions
  a_acc_needs_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_time_synced)
    else $error("accepted result without a synced clock");

  a_off_no_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    !on_rd |-> dl_rd == '0)
    else $error("relay off while a deadline stays armed");

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_hash_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HASH |-> hcnt_r < HCNT_W'(HASH_BYTES))
    else $error("hash byte counter ran past the last byte");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the result step");

endmodule

`default_nettype wire
